/* design/fsd_pkg.sv */
// fsd_pkg: shared constants, config, command and result types for the Floyd-Steinberg dither.
// Used by every module of floyd_steinberg_dither; depends on nothing.
package fsd_pkg;

  localparam int MaxWidth  = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = ColW + 1;
  localparam int FracBits  = 24;
  localparam int Fb        = FracBits + 4;
  localparam int ErrW      = FracBits + 2;

  localparam int SampleW   = 16;
  localparam int LevelW    = 16;
  localparam int BitsW     = 5;
  localparam int WidthCfgW = 13;
  localparam int ScaleW    = 40;
  localparam int OffsetW   = 42;

  localparam int ScaleLoW  = ScaleW / 2;
  localparam int ProdW     = SampleW + ScaleW - ScaleLoW;
  localparam int XW        = SampleW + ScaleW + 2;
  localparam int ESumW     = ErrW + 4;
  localparam int SumW      = XW + 4;
  localparam int BaseW     = LevelW + Fb + 3;
  localparam int TotW      = BaseW + 1;
  localparam int ClampW    = LevelW + Fb;

  localparam int CmdDepth  = 4;
  localparam int CmdPtrW   = $clog2(CmdDepth);
  localparam int ResDepth  = 8;
  localparam int ResPtrW   = $clog2(ResDepth);

  localparam int ApbAddrW  = 5;
  localparam int ApbDataW  = 64;

  typedef enum logic [1:0] {
    RegScale,
    RegOffset,
    RegOutBits,
    RegRowWidth
  } reg_idx_e;

  typedef struct packed {
    logic [ScaleW-1:0]    scale;
    logic [OffsetW-1:0]   offset;
    logic [BitsW-1:0]     out_bits;
    logic [WidthCfgW-1:0] row_width;
  } cfg_t;

  typedef struct packed {
    logic [ProdW-1:0] p_lo;
    logic [ProdW-1:0] p_hi;
    logic [ColW-1:0]  col;
    logic             last;
    logic             first;
    logic [BitsW-1:0] bits;
  } cmd_t;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              end_of_row;
  } res_t;

endpackage

/* design/fsd_cfg.sv */
// fsd_cfg: APB register file holding scale, offset, out_bits and row_width.
// Depends on fsd_pkg.
module fsd_cfg import fsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  reg_idx_e idx;
  logic     wr_en;
  cfg_t     cfg_q, cfg_d;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegScale:    cfg_d.scale     = pwdata[ScaleW-1:0];
        RegOffset:   cfg_d.offset    = pwdata[OffsetW-1:0];
        RegOutBits:  cfg_d.out_bits  = pwdata[BitsW-1:0];
        RegRowWidth: cfg_d.row_width = pwdata[WidthCfgW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegScale:    prdata = ApbDataW'(cfg_q.scale);
      RegOffset:   prdata = ApbDataW'(cfg_q.offset);
      RegOutBits:  prdata = ApbDataW'(cfg_q.out_bits);
      RegRowWidth: prdata = ApbDataW'(cfg_q.row_width);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale     <= ScaleW'(1) << FracBits;
      cfg_q.offset    <= '0;
      cfg_q.out_bits  <= BitsW'(8);
      cfg_q.row_width <= WidthCfgW'(MaxWidth);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/fsd_front.sv */
// fsd_front: accepts pixels, tracks column and first-row state, splits the gain product.
// Depends on fsd_pkg; feeds fsd_cmd_fifo.
module fsd_front import fsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               start_of_frame_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [BitsW-1:0] bits;
  logic [RowW-1:0]  w;
  logic [ColW-1:0]  col_q, col_d, j;
  logic             first_q, first_d, first, last;

  always_comb begin
    if (cfg_i.out_bits == '0) begin
      bits = BitsW'(1);
    end else if (cfg_i.out_bits > BitsW'(LevelW)) begin
      bits = BitsW'(LevelW);
    end else begin
      bits = cfg_i.out_bits;
    end
    if (cfg_i.row_width == '0) begin
      w = RowW'(1);
    end else if (int'(cfg_i.row_width) > MaxWidth) begin
      w = RowW'(MaxWidth);
    end else begin
      w = RowW'(cfg_i.row_width);
    end
  end

  assign push_o = push_i && !full_i;
  assign j      = start_of_frame_i ? '0 : col_q;
  assign first  = start_of_frame_i || first_q;
  assign last   = (RowW'(j) + RowW'(1)) >= w;

  always_comb begin
    cmd_o.p_lo  = ProdW'(sample_i) * ProdW'(cfg_i.scale[ScaleLoW-1:0]);
    cmd_o.p_hi  = ProdW'(sample_i) * ProdW'(cfg_i.scale[ScaleW-1:ScaleLoW]);
    cmd_o.col   = j;
    cmd_o.last  = last;
    cmd_o.first = first;
    cmd_o.bits  = bits;
  end

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (push_o) begin
      if (last) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d   = j + ColW'(1);
        first_d = first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
    end
  end

endmodule

/* design/fsd_cmd_fifo.sv */
// fsd_cmd_fifo: short queue of classified pixels between front and back.
// Depends on fsd_pkg.
module fsd_cmd_fifo import fsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t               store_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_q, rd_q;
  logic [CmdPtrW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (CmdPtrW+1)'(CmdDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = store_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + CmdPtrW'(1);
      if (do_pop)  rd_q <= rd_q + CmdPtrW'(1);
      cnt_q <= cnt_q + (CmdPtrW+1)'(do_push) - (CmdPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) store_q[wr_q] <= cmd_i;
  end

endmodule

/* design/fsd_back.sv */
// fsd_back: line buffer, three-stage error diffusion pipeline and result queue.
// Depends on fsd_pkg; takes commands from fsd_cmd_fifo.
module fsd_back import fsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output res_t               res_o
);

  typedef struct packed {
    logic [ColW-1:0]  col;
    logic             last;
    logic [BitsW-1:0] bits;
  } tag_t;

  // line buffer
  logic [ErrW-1:0] mem [MaxWidth];
  logic signed [ErrW-1:0] rd_t_q, rd_tr_q;

  // stage registers
  logic v1_q, v2_q, v3_q;
  cmd_t s1_q;
  tag_t s2_q, s3_q;
  logic signed [XW-1:0]    x2_q;
  logic signed [ESumW-1:0] esum2_q;
  logic signed [BaseW-1:0] base3_q;
  logic signed [ErrW-1:0]  prev_top_q, last_e_q;

  // result queue
  res_t               res_q [ResDepth];
  logic [ResPtrW-1:0] res_wr_q, res_rd_q;
  logic [ResPtrW:0]   res_cnt_q;
  logic               res_pop;

  logic [ColW-1:0]    head_nx;
  logic [ResPtrW+1:0] occ;
  logic               hazard, issue;

  // issue: hold while a pixel above or above-right is in flight or no result slot is free
  assign head_nx = cmd_i.col + ColW'(1);
  assign occ = (ResPtrW+2)'(res_cnt_q) + (ResPtrW+2)'(v1_q) + (ResPtrW+2)'(v2_q)
             + (ResPtrW+2)'(v3_q);

  always_comb begin
    hazard = 1'b0;
    if (!cmd_i.first) begin
      if (v1_q && (s1_q.col == cmd_i.col || (!cmd_i.last && s1_q.col == head_nx)))
        hazard = 1'b1;
      if (v2_q && (s2_q.col == cmd_i.col || (!cmd_i.last && s2_q.col == head_nx)))
        hazard = 1'b1;
      if (v3_q && (s3_q.col == cmd_i.col || (!cmd_i.last && s3_q.col == head_nx)))
        hazard = 1'b1;
    end
  end

  assign issue     = !cmd_empty_i && !hazard && (occ < (ResPtrW+2)'(ResDepth));
  assign cmd_pop_o = issue;

  // stage 1: neighbor errors and scaled sample
  logic signed [ErrW-1:0]  top, top_r, top_l;
  logic signed [ESumW-1:0] t_x, tr_x, tl_x, esum;
  logic signed [XW-1:0]    hi_x, lo_x, off_x, x;

  always_comb begin
    top   = s1_q.first ? '0 : rd_t_q;
    top_r = (s1_q.first || s1_q.last) ? '0 : rd_tr_q;
    top_l = (s1_q.col == '0) ? '0 : prev_top_q;
    t_x   = {{(ESumW-ErrW){top[ErrW-1]}}, top};
    tr_x  = {{(ESumW-ErrW){top_r[ErrW-1]}}, top_r};
    tl_x  = {{(ESumW-ErrW){top_l[ErrW-1]}}, top_l};
    esum  = (tr_x <<< 1) + tr_x + (t_x <<< 2) + t_x + tl_x;
    hi_x  = XW'({s1_q.p_hi, {ScaleLoW{1'b0}}});
    lo_x  = XW'(s1_q.p_lo);
    off_x = {{(XW-OffsetW){cfg_i.offset[OffsetW-1]}}, cfg_i.offset};
    x     = hi_x + lo_x + off_x;
  end

  // stage 2: x * 16 plus errors, saturated to a range the clamp cannot miss
  logic signed [SumW-1:0]  sum;
  logic signed [BaseW-1:0] base;

  always_comb begin
    sum = {x2_q, 4'b0000} + {{(SumW-ESumW){esum2_q[ESumW-1]}}, esum2_q};
    if (&sum[SumW-1:BaseW-1] || ~|sum[SumW-1:BaseW-1]) begin
      base = sum[BaseW-1:0];
    end else if (sum[SumW-1]) begin
      base = {1'b1, {(BaseW-1){1'b0}}};
    end else begin
      base = {1'b0, {(BaseW-1){1'b1}}};
    end
  end

  // stage 3: left error feedback, clamp, round half to even, residual
  logic signed [ErrW-1:0] left;
  logic signed [TotW-1:0] b_x, l_x, total;
  logic [LevelW:0]        lim;
  logic [LevelW-1:0]      lvl_max, q, level;
  logic [ClampW-1:0]      maxv, tc;
  logic [Fb-1:0]          rem, half;
  logic                   up;
  logic [Fb:0]            resid, rs8;
  logic signed [ErrW-1:0] e;

  always_comb begin
    left    = (s3_q.col == '0) ? '0 : last_e_q;
    b_x     = {base3_q[BaseW-1], base3_q};
    l_x     = {{(TotW-ErrW){left[ErrW-1]}}, left};
    total   = b_x + (l_x <<< 3) - l_x;
    lim     = (LevelW+1)'(1) << s3_q.bits;
    lvl_max = LevelW'(lim - (LevelW+1)'(1));
    maxv    = {lvl_max, {Fb{1'b0}}};
    if (total[TotW-1]) begin
      tc = '0;
    end else if (total[TotW-2:0] > (TotW-1)'(maxv)) begin
      tc = maxv;
    end else begin
      tc = total[ClampW-1:0];
    end
    q     = tc[ClampW-1:Fb];
    rem   = tc[Fb-1:0];
    half  = {1'b1, {(Fb-1){1'b0}}};
    up    = (rem > half) || (rem == half && q[0]);
    level = q + LevelW'(up);
    resid = {1'b0, rem} - {up, {Fb{1'b0}}};
    rs8   = resid + (Fb+1)'(8);
    e     = {rs8[Fb], rs8[Fb:4]};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q)    res_wr_q <= res_wr_q + ResPtrW'(1);
      if (res_pop) res_rd_q <= res_rd_q + ResPtrW'(1);
      res_cnt_q <= res_cnt_q + (ResPtrW+1)'(v3_q) - (ResPtrW+1)'(res_pop);
    end
  end

  // datapath and memories
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_q    <= cmd_i;
      rd_t_q  <= mem[cmd_i.col];
      rd_tr_q <= mem[head_nx];
    end
    if (v1_q) begin
      x2_q       <= x;
      esum2_q    <= esum;
      prev_top_q <= top;
      s2_q.col   <= s1_q.col;
      s2_q.last  <= s1_q.last;
      s2_q.bits  <= s1_q.bits;
    end
    if (v2_q) begin
      base3_q <= base;
      s3_q    <= s2_q;
    end
    if (v3_q) begin
      mem[s3_q.col]            <= e;
      last_e_q                 <= e;
      res_q[res_wr_q].level      <= level;
      res_q[res_wr_q].end_of_row <= s3_q.last;
    end
  end

  assign empty_o = res_cnt_q == '0;
  assign res_pop = pop_i && !empty_o;
  assign res_o   = res_q[res_rd_q];

endmodule

/* design/floyd_steinberg_dither.sv */
// floyd_steinberg_dither: top level of the Floyd-Steinberg error-diffusion ditherer.
// Depends on fsd_pkg, fsd_cfg, fsd_front, fsd_cmd_fifo and fsd_back.
//
//   channel   handshake            payload                         transfer when
//   input     push / full          sample_i, start_of_frame_i      push && !full
//   result    pop / empty          level_o, end_of_row_o           pop && !empty
//   config    psel/penable/pwrite  paddr (8*i), pwdata, prdata     psel && penable && pwrite
//
// One pixel per cycle for rows of 5 or more pixels while results are popped. Rows of 4 or
// fewer pixels run slower, slowest at width 1: a pixel enters the back pipeline only once
// the line-buffer writes of the pixels above and above-right have landed. Results stall
// through an 8-deep queue; the input side sees full when it backs up too or narrow rows
// hold issue. Reset clears control state only; the line buffer needs no clearing pass.
module floyd_steinberg_dither import fsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [SampleW-1:0]  sample_i,
  input  logic                start_of_frame_i,
  input  logic                pop,
  output logic                empty,
  output logic [LevelW-1:0]   level_o,
  output logic                end_of_row_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;
  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_pop, cmd_empty;
  res_t res;

  fsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsd_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .push_i           (push),
    .full_i           (full),
    .sample_i         (sample_i),
    .start_of_frame_i (start_of_frame_i),
    .push_o           (cmd_push),
    .cmd_o            (cmd_in)
  );

  fsd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  fsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign level_o      = res.level;
  assign end_of_row_o = res.end_of_row;

endmodule
